@@ src/bis_pkg.sv @@
// Shared types, register indexes and reset values of the burner ignition sequencer.
// No dependencies; used by bis_cfg, bis_step and the top level.
`default_nettype none

package bis_pkg;

    // One-hot sequencer phases
    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_IGNITE  = 6'b000010,
        PH_RETRY   = 6'b000100,
        PH_LOCK    = 6'b001000,
        PH_OVERLAP = 6'b010000,
        PH_RUN     = 6'b100000
    } t_phase;

    // Phase codes as shown on the result beat
    localparam logic [2:0] CODE_IDLE    = 3'd0;
    localparam logic [2:0] CODE_IGNITE  = 3'd1;
    localparam logic [2:0] CODE_RETRY   = 3'd2;
    localparam logic [2:0] CODE_LOCK    = 3'd3;
    localparam logic [2:0] CODE_OVERLAP = 3'd4;
    localparam logic [2:0] CODE_RUN     = 3'd5;

    // Lamp state bits
    localparam logic [1:0] LAMP_OFF   = 2'b00;
    localparam logic [1:0] LAMP_RED   = 2'b01;
    localparam logic [1:0] LAMP_GREEN = 2'b10;

    // Configuration register indexes
    localparam logic [2:0] CFG_IGNITE    = 3'd0;
    localparam logic [2:0] CFG_RETRY     = 3'd1;
    localparam logic [2:0] CFG_LOCKOUT   = 3'd2;
    localparam logic [2:0] CFG_OVERLAP   = 3'd3;
    localparam logic [2:0] CFG_MAX_FAILS = 3'd4;
    localparam logic [2:0] CFG_MAX_LOSS  = 3'd5;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 16;

    // Configuration reset values
    localparam logic [7:0]  RST_IGNITE    = 8'd1;
    localparam logic [7:0]  RST_RETRY     = 8'd2;
    localparam logic [15:0] RST_LOCKOUT   = 16'd300;
    localparam logic [7:0]  RST_OVERLAP   = 8'd2;
    localparam logic [3:0]  RST_MAX_FAILS = 4'd5;
    localparam logic [3:0]  RST_MAX_LOSS  = 4'd5;

    localparam logic [15:0] TICK_MAX = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  ignite_seconds;
        logic [7:0]  retry_wait_seconds;
        logic [15:0] lockout_seconds;
        logic [7:0]  overlap_seconds;
        logic [3:0]  max_ignite_fails;
        logic [3:0]  max_flame_losses;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] tick_count;
        logic [3:0]  ignite_fail_count;
        logic [3:0]  flame_loss_count;
        logic        lockout_to_ignite;
        logic [1:0]  lamp_state;
    } t_state;

    typedef struct packed {
        logic       igniter_on;
        logic       pilot_open;
        logic       main_open;
        logic       lamp_red;
        logic       lamp_green;
        logic [2:0] phase;
    } t_result;

    // Map a one-hot phase to its result code
    function automatic logic [2:0] phase_code(input t_phase ph);
        logic [2:0] code;
        case (ph)
            PH_IDLE:    code = CODE_IDLE;
            PH_IGNITE:  code = CODE_IGNITE;
            PH_RETRY:   code = CODE_RETRY;
            PH_LOCK:    code = CODE_LOCK;
            PH_OVERLAP: code = CODE_OVERLAP;
            PH_RUN:     code = CODE_RUN;
            default:    code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

@@ src/bis_cfg.sv @@
// Configuration register bank of the burner ignition sequencer.
// Depends on bis_pkg for register indexes, reset values and t_cfg.
`default_nettype none

module bis_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [bis_pkg::CfgIndexWidth-1:0] i_cfg_index,
    input  wire logic [bis_pkg::CfgDataWidth-1:0]  i_cfg_data,
    output bis_pkg::t_cfg                          o_cfg
);

    bis_pkg::t_cfg r_cfg;

    // Load the addressed register; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ignite_seconds     <= bis_pkg::RST_IGNITE;
            r_cfg.retry_wait_seconds <= bis_pkg::RST_RETRY;
            r_cfg.lockout_seconds    <= bis_pkg::RST_LOCKOUT;
            r_cfg.overlap_seconds    <= bis_pkg::RST_OVERLAP;
            r_cfg.max_ignite_fails   <= bis_pkg::RST_MAX_FAILS;
            r_cfg.max_flame_losses   <= bis_pkg::RST_MAX_LOSS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bis_pkg::CFG_IGNITE:    r_cfg.ignite_seconds     <= i_cfg_data[7:0];
                bis_pkg::CFG_RETRY:     r_cfg.retry_wait_seconds <= i_cfg_data[7:0];
                bis_pkg::CFG_LOCKOUT:   r_cfg.lockout_seconds    <= i_cfg_data[15:0];
                bis_pkg::CFG_OVERLAP:   r_cfg.overlap_seconds    <= i_cfg_data[7:0];
                bis_pkg::CFG_MAX_FAILS: r_cfg.max_ignite_fails   <= i_cfg_data[3:0];
                bis_pkg::CFG_MAX_LOSS:  r_cfg.max_flame_losses   <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ src/bis_step.sv @@
// Next-state and result logic for one tick of the burner ignition sequencer.
// Depends on bis_pkg for t_state, t_cfg, t_result and the phase codes.
`default_nettype none

module bis_step (
    input  wire bis_pkg::t_state i_state,
    input  wire bis_pkg::t_cfg   i_cfg,
    input  wire logic            i_heat,
    input  wire logic            i_flame,
    input  wire logic            i_hot,
    output bis_pkg::t_state      o_state,
    output bis_pkg::t_result     o_result
);

    logic [15:0] tick_inc;
    logic [15:0] limit;
    logic        done;
    logic [4:0]  fails_inc;
    logic [4:0]  losses_inc;

    // Saturating tick count and end-of-phase check
    always_comb begin
        tick_inc = (i_state.tick_count == bis_pkg::TICK_MAX) ? i_state.tick_count
                 : i_state.tick_count + 16'd1;
        case (i_state.phase)
            bis_pkg::PH_IGNITE:  limit = {8'd0, i_cfg.ignite_seconds};
            bis_pkg::PH_RETRY:   limit = {8'd0, i_cfg.retry_wait_seconds};
            bis_pkg::PH_LOCK:    limit = i_cfg.lockout_seconds;
            bis_pkg::PH_OVERLAP: limit = {8'd0, i_cfg.overlap_seconds};
            default:             limit = 16'd0;
        endcase
        done       = (tick_inc >= limit);
        fails_inc  = {1'b0, i_state.ignite_fail_count} + 5'd1;
        losses_inc = {1'b0, i_state.flame_loss_count} + 5'd1;
    end

    // Phase transitions
    always_comb begin
        o_state = i_state;
        case (i_state.phase)
            bis_pkg::PH_IDLE: begin
                if (i_heat) begin
                    o_state.phase      = bis_pkg::PH_IGNITE;
                    o_state.tick_count = 16'd0;
                    o_state.lamp_state = bis_pkg::LAMP_GREEN;
                end
            end
            bis_pkg::PH_IGNITE: begin
                o_state.tick_count = tick_inc;
                if (done) begin
                    o_state.tick_count = 16'd0;
                    if (i_flame) begin
                        o_state.phase = bis_pkg::PH_OVERLAP;
                    end else begin
                        o_state.lamp_state = bis_pkg::LAMP_RED;
                        if (fails_inc > {1'b0, i_cfg.max_ignite_fails}) begin
                            o_state.ignite_fail_count = 4'd0;
                            o_state.phase             = bis_pkg::PH_LOCK;
                            o_state.lockout_to_ignite = 1'b1;
                        end else begin
                            o_state.ignite_fail_count = fails_inc[3:0];
                            o_state.phase             = bis_pkg::PH_RETRY;
                        end
                    end
                end
            end
            bis_pkg::PH_RETRY: begin
                o_state.tick_count = tick_inc;
                if (done) begin
                    o_state.phase      = bis_pkg::PH_IGNITE;
                    o_state.tick_count = 16'd0;
                    o_state.lamp_state = bis_pkg::LAMP_GREEN;
                end
            end
            bis_pkg::PH_LOCK: begin
                o_state.tick_count = tick_inc;
                if (done) begin
                    o_state.tick_count = 16'd0;
                    if (i_state.lockout_to_ignite) begin
                        o_state.phase      = bis_pkg::PH_IGNITE;
                        o_state.lamp_state = bis_pkg::LAMP_GREEN;
                    end else begin
                        o_state.phase             = bis_pkg::PH_IDLE;
                        o_state.ignite_fail_count = 4'd0;
                        o_state.flame_loss_count  = 4'd0;
                    end
                end
            end
            bis_pkg::PH_OVERLAP: begin
                o_state.tick_count = tick_inc;
                if (done) begin
                    o_state.phase      = bis_pkg::PH_RUN;
                    o_state.tick_count = 16'd0;
                end
            end
            bis_pkg::PH_RUN: begin
                if (!i_heat) begin
                    o_state.phase             = bis_pkg::PH_IDLE;
                    o_state.tick_count        = 16'd0;
                    o_state.ignite_fail_count = 4'd0;
                    o_state.flame_loss_count  = 4'd0;
                end else if (!i_flame) begin
                    o_state.tick_count = 16'd0;
                    if (losses_inc > {1'b0, i_cfg.max_flame_losses}) begin
                        o_state.lamp_state        = bis_pkg::LAMP_RED;
                        o_state.flame_loss_count  = 4'd0;
                        o_state.phase             = bis_pkg::PH_LOCK;
                        o_state.lockout_to_ignite = 1'b0;
                    end else begin
                        // restart ignition turns the lamp back to green
                        o_state.lamp_state       = bis_pkg::LAMP_GREEN;
                        o_state.flame_loss_count = losses_inc[3:0];
                        o_state.phase            = bis_pkg::PH_IGNITE;
                    end
                end else if (i_hot) begin
                    o_state.lamp_state        = bis_pkg::LAMP_RED;
                    o_state.tick_count        = 16'd0;
                    o_state.phase             = bis_pkg::PH_LOCK;
                    o_state.lockout_to_ignite = 1'b0;
                end
            end
            default: begin
                o_state.phase             = bis_pkg::PH_IDLE;
                o_state.tick_count        = 16'd0;
                o_state.ignite_fail_count = 4'd0;
                o_state.flame_loss_count  = 4'd0;
            end
        endcase
    end

    // Drive outputs from the state after this tick
    always_comb begin
        o_result.igniter_on = (o_state.phase == bis_pkg::PH_IGNITE);
        o_result.pilot_open = (o_state.phase == bis_pkg::PH_IGNITE) ||
                              (o_state.phase == bis_pkg::PH_OVERLAP);
        o_result.main_open  = (o_state.phase == bis_pkg::PH_OVERLAP) ||
                              (o_state.phase == bis_pkg::PH_RUN);
        o_result.lamp_red   = o_state.lamp_state[0];
        o_result.lamp_green = o_state.lamp_state[1];
        o_result.phase      = bis_pkg::phase_code(o_state.phase);
    end

endmodule

`default_nettype wire

@@ src/burner_ignition_sequencer_unit.sv @@
// Top level of the burner ignition sequencer: input register, state, result register.
// Depends on bis_pkg, bis_cfg and bis_step.
//
//  channel | direction | handshake                 | payload
//  in      | sink      | i_in_valid / o_in_stall   | heat_request, flame_sensed, over_temp
//  out     | source    | o_out_valid / i_out_stall | igniter_on .. lamp_green, phase
//  cfg     | sink      | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// An accepted beat is captured in the input register, then moves through the next-state
// logic into the result register, where its result becomes valid. One beat per cycle
// is sustained while the result side does not stall; the phase state updates as a beat
// moves into the result register.
// Reset (synchronous, active low) returns to idle with counters cleared, lamps off
// and registers at their defaults. A stall on the result side holds the result
// register and backs up into the input register, then into o_in_stall.
`default_nettype none

module burner_ignition_sequencer_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output      logic                              o_in_stall,
    input  wire logic                              i_heat_request,
    input  wire logic                              i_flame_sensed,
    input  wire logic                              i_over_temp,
    output      logic                              o_out_valid,
    input  wire logic                              i_out_stall,
    output      logic                              o_igniter_on,
    output      logic                              o_pilot_open,
    output      logic                              o_main_open,
    output      logic                              o_lamp_red,
    output      logic                              o_lamp_green,
    output      logic [2:0]                        o_phase,
    input  wire logic                              i_cfg_we,
    input  wire logic [bis_pkg::CfgIndexWidth-1:0] i_cfg_index,
    input  wire logic [bis_pkg::CfgDataWidth-1:0]  i_cfg_data
);

    bis_pkg::t_cfg    cfg;
    bis_pkg::t_state  r_state;
    bis_pkg::t_state  n_state;
    bis_pkg::t_result n_result;
    bis_pkg::t_result r_result;

    logic r_in_valid;
    logic r_heat;
    logic r_flame;
    logic r_hot;
    logic r_out_valid;
    logic out_free;
    logic advance;
    logic in_take;

    bis_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bis_step u_step (
        .i_state  (r_state),
        .i_cfg    (cfg),
        .i_heat   (r_heat),
        .i_flame  (r_flame),
        .i_hot    (r_hot),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Handshake between the two register stages
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Capture the input beat
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_heat  <= i_heat_request;
            r_flame <= i_flame_sensed;
            r_hot   <= i_over_temp;
        end
    end

    // Advance sequencer state once per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase             <= bis_pkg::PH_IDLE;
            r_state.tick_count        <= 16'd0;
            r_state.ignite_fail_count <= 4'd0;
            r_state.flame_loss_count  <= 4'd0;
            r_state.lockout_to_ignite <= 1'b0;
            r_state.lamp_state        <= bis_pkg::LAMP_OFF;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the result beat
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_igniter_on = r_result.igniter_on;
    assign o_pilot_open = r_result.pilot_open;
    assign o_main_open  = r_result.main_open;
    assign o_lamp_red   = r_result.lamp_red;
    assign o_lamp_green = r_result.lamp_green;
    assign o_phase      = r_result.phase;

endmodule

`default_nettype wire

@@ src/bis_checker.sv @@
// Port-level checks for the burner ignition sequencer, bound to the top level.
// Depends on bis_pkg for phase codes and burner_ignition_sequencer_unit's ports.
`default_nettype none

module bis_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic       o_igniter_on,
    input wire logic       o_pilot_open,
    input wire logic       o_main_open,
    input wire logic       o_lamp_red,
    input wire logic       o_lamp_green,
    input wire logic [2:0] o_phase
);

    // A stalled result beat stays and keeps its phase, lamps and main valve
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_phase) &&
        $stable(o_lamp_red) && $stable(o_lamp_green) && $stable(o_main_open))
        else $error("result beat changed while stalled");

    // Igniter runs only in ignite, always with the pilot open
    a_igniter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_igniter_on == (o_phase == bis_pkg::CODE_IGNITE)) &&
        (!o_igniter_on || o_pilot_open))
        else $error("igniter does not match ignite phase");

    // Main valve follows overlap and run
    a_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_main_open ==
        ((o_phase == bis_pkg::CODE_OVERLAP) || (o_phase == bis_pkg::CODE_RUN)))
        else $error("main valve does not match phase");

    // Never both lamps lit, and the phase code stays in range
    a_lamp_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_lamp_red && o_lamp_green) && (o_phase <= bis_pkg::CODE_RUN))
        else $error("lamp or phase code out of range");

endmodule

bind burner_ignition_sequencer_unit bis_checker u_bis_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_igniter_on (o_igniter_on),
    .o_pilot_open (o_pilot_open),
    .o_main_open  (o_main_open),
    .o_lamp_red   (o_lamp_red),
    .o_lamp_green (o_lamp_green),
    .o_phase      (o_phase)
);

`default_nettype wire

@@ sim/burner_ignition_sequencer_checker.sv @@
// Checker for the burner ignition sequencer: follows register writes, predicts the
// drive outputs of every accepted tick beat and compares them with the result beats.
// Depends on bis_pkg; instantiated by burner_ignition_sequencer_unit_tb.
`timescale 1ns / 1ps

module burner_ignition_sequencer_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire logic                              i_in_stall,
    input  wire logic                              i_heat_request,
    input  wire logic                              i_flame_sensed,
    input  wire logic                              i_over_temp,
    input  wire logic                              i_out_valid,
    input  wire logic                              i_out_stall,
    input  wire logic                              i_igniter_on,
    input  wire logic                              i_pilot_open,
    input  wire logic                              i_main_open,
    input  wire logic                              i_lamp_red,
    input  wire logic                              i_lamp_green,
    input  wire logic [2:0]                        i_phase,
    input  wire logic                              i_cfg_we,
    input  wire logic [bis_pkg::CfgIndexWidth-1:0] i_cfg_index,
    input  wire logic [bis_pkg::CfgDataWidth-1:0]  i_cfg_data,
    output int                                     o_mismatch_count,
    output int                                     o_ticks_in_flight
);

    // Register copy and sequencer state as the block should hold them
    bis_pkg::t_cfg    timing;
    logic [2:0]       seq_phase;
    logic [15:0]      seq_ticks;
    logic [3:0]       seq_fails;
    logic [3:0]       seq_losses;
    logic             seq_lock_to_ignite;
    logic [1:0]       seq_lamps;

    bis_pkg::t_result drive_q[$];
    int               mismatch_count = 0;
    int               queued = 0;

    assign o_mismatch_count  = mismatch_count;
    assign o_ticks_in_flight = queued;

    function automatic void clear_sequencer();
        timing.ignite_seconds     = bis_pkg::RST_IGNITE;
        timing.retry_wait_seconds = bis_pkg::RST_RETRY;
        timing.lockout_seconds    = bis_pkg::RST_LOCKOUT;
        timing.overlap_seconds    = bis_pkg::RST_OVERLAP;
        timing.max_ignite_fails   = bis_pkg::RST_MAX_FAILS;
        timing.max_flame_losses   = bis_pkg::RST_MAX_LOSS;
        seq_phase          = bis_pkg::CODE_IDLE;
        seq_ticks          = '0;
        seq_fails          = '0;
        seq_losses         = '0;
        seq_lock_to_ignite = 1'b0;
        seq_lamps          = bis_pkg::LAMP_OFF;
    endfunction

    function automatic void write_timing(input logic [2:0] idx, input logic [15:0] data);
        case (idx)
            bis_pkg::CFG_IGNITE:    timing.ignite_seconds     = data[7:0];
            bis_pkg::CFG_RETRY:     timing.retry_wait_seconds = data[7:0];
            bis_pkg::CFG_LOCKOUT:   timing.lockout_seconds    = data;
            bis_pkg::CFG_OVERLAP:   timing.overlap_seconds    = data[7:0];
            bis_pkg::CFG_MAX_FAILS: timing.max_ignite_fails   = data[3:0];
            bis_pkg::CFG_MAX_LOSS:  timing.max_flame_losses   = data[3:0];
            default: ;
        endcase
    endfunction

    function automatic void enter_phase(input logic [2:0] ph);
        seq_phase = ph;
        seq_ticks = '0;
    endfunction

    // Count one tick in a timed phase, saturating; true once the limit is reached
    function automatic logic tick_done(input logic [15:0] limit);
        if (seq_ticks != bis_pkg::TICK_MAX) begin
            seq_ticks = seq_ticks + 16'd1;
        end
        return seq_ticks >= limit;
    endfunction

    function automatic void start_ignition();
        enter_phase(bis_pkg::CODE_IGNITE);
        seq_lamps = bis_pkg::LAMP_GREEN;
    endfunction

    function automatic void end_heat_cycle();
        enter_phase(bis_pkg::CODE_IDLE);
        seq_fails  = '0;
        seq_losses = '0;
    endfunction

    function automatic void lock_out(input logic to_ignite);
        enter_phase(bis_pkg::CODE_LOCK);
        seq_lock_to_ignite = to_ignite;
    endfunction

    // Advance the sequencer by one tick and return the drive outputs after it
    function automatic bis_pkg::t_result predict_tick(input logic heat, input logic flame,
                                                      input logic hot);
        logic [4:0]       count;
        bis_pkg::t_result drive;
        case (seq_phase)
            bis_pkg::CODE_IDLE: begin
                if (heat) start_ignition();
            end
            bis_pkg::CODE_IGNITE: begin
                if (tick_done({8'd0, timing.ignite_seconds})) begin
                    if (flame) begin
                        enter_phase(bis_pkg::CODE_OVERLAP);
                    end else begin
                        seq_lamps = bis_pkg::LAMP_RED;
                        count = {1'b0, seq_fails} + 5'd1;
                        if (count > {1'b0, timing.max_ignite_fails}) begin
                            seq_fails = '0;
                            lock_out(1'b1);
                        end else begin
                            seq_fails = count[3:0];
                            enter_phase(bis_pkg::CODE_RETRY);
                        end
                    end
                end
            end
            bis_pkg::CODE_RETRY: begin
                if (tick_done({8'd0, timing.retry_wait_seconds})) start_ignition();
            end
            bis_pkg::CODE_LOCK: begin
                if (tick_done(timing.lockout_seconds)) begin
                    if (seq_lock_to_ignite) start_ignition();
                    else end_heat_cycle();
                end
            end
            bis_pkg::CODE_OVERLAP: begin
                if (tick_done({8'd0, timing.overlap_seconds})) begin
                    enter_phase(bis_pkg::CODE_RUN);
                end
            end
            bis_pkg::CODE_RUN: begin
                // heat request first, then flame, then temperature
                if (!heat) begin
                    end_heat_cycle();
                end else if (!flame) begin
                    seq_lamps = bis_pkg::LAMP_RED;
                    count = {1'b0, seq_losses} + 5'd1;
                    if (count > {1'b0, timing.max_flame_losses}) begin
                        seq_losses = '0;
                        lock_out(1'b0);
                    end else begin
                        seq_losses = count[3:0];
                        start_ignition();
                    end
                end else if (hot) begin
                    seq_lamps = bis_pkg::LAMP_RED;
                    lock_out(1'b0);
                end
            end
            default: end_heat_cycle();
        endcase
        drive.igniter_on = (seq_phase == bis_pkg::CODE_IGNITE);
        drive.pilot_open = (seq_phase == bis_pkg::CODE_IGNITE) ||
                           (seq_phase == bis_pkg::CODE_OVERLAP);
        drive.main_open  = (seq_phase == bis_pkg::CODE_OVERLAP) ||
                           (seq_phase == bis_pkg::CODE_RUN);
        drive.lamp_red   = (seq_lamps & bis_pkg::LAMP_RED) != bis_pkg::LAMP_OFF;
        drive.lamp_green = (seq_lamps & bis_pkg::LAMP_GREEN) != bis_pkg::LAMP_OFF;
        drive.phase      = seq_phase;
        return drive;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    // Follow writes, compare result beats, predict on tick beats
    always @(posedge i_clk) begin : track
        bis_pkg::t_result want;
        if (!i_rst_n) begin
            clear_sequencer();
            drive_q.delete();
        end else begin
            if (i_cfg_we) write_timing(i_cfg_index, i_cfg_data);
            if (i_out_valid && !i_out_stall) begin
                if (drive_q.size() == 0) begin
                    $error("result beat with no tick outstanding");
                    mismatch_count++;
                end else begin
                    want = drive_q.pop_front();
                    check_field("igniter_on", want.igniter_on, i_igniter_on);
                    check_field("pilot_open", want.pilot_open, i_pilot_open);
                    check_field("main_open",  want.main_open,  i_main_open);
                    check_field("lamp_red",   want.lamp_red,   i_lamp_red);
                    check_field("lamp_green", want.lamp_green, i_lamp_green);
                    check_field("phase",      want.phase,      i_phase);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                drive_q.push_back(predict_tick(i_heat_request, i_flame_sensed, i_over_temp));
            end
        end
        queued = drive_q.size();
    end

endmodule

@@ sim/burner_ignition_sequencer_unit_tb.sv @@
// Testbench top for burner_ignition_sequencer_unit: clock, reset, register setups,
// tick beats and result-side stalls; the verdict comes from the checker's count.
// Depends on bis_pkg, the block and burner_ignition_sequencer_checker.
`timescale 1ns / 1ps

module burner_ignition_sequencer_unit_tb;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int LONG_HOLD      = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WALK_LEN       = 27;

    // Indexes that select no register
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    logic                              clk           = 1'b0;
    logic                              rst_n         = 1'b0;
    logic                              in_valid      = 1'b0;
    logic                              in_stall;
    logic                              heat_request  = 1'b0;
    logic                              flame_sensed  = 1'b0;
    logic                              over_temp     = 1'b0;
    logic                              out_valid;
    logic                              out_stall     = 1'b0;
    logic                              igniter_on;
    logic                              pilot_open;
    logic                              main_open;
    logic                              lamp_red;
    logic                              lamp_green;
    logic [2:0]                        phase;
    logic                              cfg_we        = 1'b0;
    logic [bis_pkg::CfgIndexWidth-1:0] cfg_index     = '0;
    logic [bis_pkg::CfgDataWidth-1:0]  cfg_data      = '0;

    int mismatches;
    int ticks_in_flight;
    int quiet_cycles = 0;
    bit idle_on = 1'b0;
    bit hold_out_long = 1'b0;

    // Directed walk, {heat, flame, over_temp} per tick: every phase, every exit
    logic [2:0] walk_ticks [WALK_LEN] = '{
        3'b000, 3'b011, 3'b100, 3'b100, 3'b001, 3'b100, 3'b000, 3'b000, 3'b110,
        3'b001, 3'b110, 3'b100, 3'b110, 3'b111, 3'b101, 3'b111, 3'b111, 3'b110,
        3'b110, 3'b110, 3'b111, 3'b000, 3'b000, 3'b110, 3'b110, 3'b110, 3'b010
    };

    always #CLK_HALF clk = ~clk;

    burner_ignition_sequencer_unit u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_heat_request (heat_request),
        .i_flame_sensed (flame_sensed),
        .i_over_temp    (over_temp),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_igniter_on   (igniter_on),
        .o_pilot_open   (pilot_open),
        .o_main_open    (main_open),
        .o_lamp_red     (lamp_red),
        .o_lamp_green   (lamp_green),
        .o_phase        (phase),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    burner_ignition_sequencer_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_heat_request    (heat_request),
        .i_flame_sensed    (flame_sensed),
        .i_over_temp       (over_temp),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_igniter_on      (igniter_on),
        .i_pilot_open      (pilot_open),
        .i_main_open       (main_open),
        .i_lamp_red        (lamp_red),
        .i_lamp_green      (lamp_green),
        .i_phase           (phase),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_mismatch_count  (mismatches),
        .o_ticks_in_flight (ticks_in_flight)
    );

    // Offer one tick beat, after an optional gap; return at the accepting edge
    task automatic send_tick(input logic heat, input logic flame, input logic hot);
        int gap;
        if (idle_on && !hold_out_long && $urandom_range(5) == 0) begin
            in_valid <= 1'b0;
            gap = $urandom_range(14, 1);
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        heat_request <= heat;
        flame_sensed <= flame;
        over_temp    <= hot;
        @(negedge clk);
        while (in_stall) @(negedge clk);
        @(posedge clk);
    endtask

    // Drop valid and wait until every tick has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (ticks_in_flight != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Write all six registers; unused upper data bits carry random junk
    task automatic configure(input logic [7:0] ign, input logic [7:0] retry,
                             input logic [15:0] lockout, input logic [7:0] overlap,
                             input logic [3:0] fails, input logic [3:0] losses);
        write_reg(bis_pkg::CFG_IGNITE,    {8'($urandom_range(255)), ign});
        write_reg(bis_pkg::CFG_RETRY,     {8'($urandom_range(255)), retry});
        write_reg(bis_pkg::CFG_LOCKOUT,   lockout);
        write_reg(bis_pkg::CFG_OVERLAP,   {8'($urandom_range(255)), overlap});
        write_reg(bis_pkg::CFG_MAX_FAILS, {12'($urandom_range(4095)), fails});
        write_reg(bis_pkg::CFG_MAX_LOSS,  {12'($urandom_range(4095)), losses});
        cfg_we <= 1'b0;
    endtask

    // Random ticks in segments that hold a heat/flame/temperature bias
    task automatic random_ticks(input int count);
        int seg;
        int heat_pct;
        int flame_pct;
        int hot_pct;
        seg = 0;
        heat_pct = 0;
        flame_pct = 0;
        hot_pct = 0;
        for (int k = 0; k < count; k++) begin
            if (seg == 0) begin
                seg = $urandom_range(40, 1);
                case ($urandom_range(3))
                    0: heat_pct = 0;
                    1: heat_pct = 50;
                    2: heat_pct = 95;
                    default: heat_pct = 100;
                endcase
                case ($urandom_range(4))
                    0: flame_pct = 0;
                    1: flame_pct = 10;
                    2: flame_pct = 50;
                    3: flame_pct = 90;
                    default: flame_pct = 100;
                endcase
                case ($urandom_range(2))
                    0: hot_pct = 0;
                    1: hot_pct = 3;
                    default: hot_pct = 25;
                endcase
            end
            seg--;
            send_tick($urandom_range(99) < heat_pct, $urandom_range(99) < flame_pct,
                      $urandom_range(99) < hot_pct);
        end
    endtask

    task automatic random_setup();
        configure(8'($urandom_range(4, 1)), 8'($urandom_range(3, 1)),
                  16'($urandom_range(8, 1)), 8'($urandom_range(3, 1)),
                  4'($urandom_range(15)), 4'($urandom_range(15)));
    endtask

    // Result side: random stall bursts, and one long hold-off when asked
    initial begin : result_side
        int burst;
        forever begin
            @(posedge clk);
            if (hold_out_long) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_out_long = 1'b0;
                out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(7) == 0) begin
                out_stall <= 1'b1;
                burst = $urandom_range(14, 1);
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // End the run when no beat moves on either channel for too long
    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on = 1'b1;

        // Walk every phase with tight limits
        configure(8'd1, 8'd1, 16'd2, 8'd1, 4'd1, 4'd1);
        foreach (walk_ticks[k]) begin
            send_tick(walk_ticks[k][2], walk_ticks[k][1], walk_ticks[k][0]);
        end
        settle();

        // Spare indexes take junk; then all registers zero
        write_reg(CFG_SPARE_LO, 16'($urandom_range(65535)));
        write_reg(CFG_SPARE_HI, 16'hFFFF);
        configure(8'd0, 8'd0, 16'd0, 8'd0, 4'd0, 4'd0);
        random_ticks(120);
        settle();

        // Longest ignite, retry and overlap times, highest limits
        configure(8'd255, 8'd255, 16'd300, 8'd255, 4'd15, 4'd15);
        random_ticks(250);
        settle();

        // Sixteenth failure or loss locks out; result side holds off to back up input
        configure(8'd1, 8'd1, 16'd3, 8'd1, 4'd15, 4'd15);
        hold_out_long = 1'b1;
        random_ticks(200);
        settle();

        // Lockout longer than eight bits can hold
        configure(8'd2, 8'd1, 16'h0101, 8'd1, 4'd0, 4'd0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        random_ticks(330);
        settle();

        // Longest lockout
        configure(8'd1, 8'd1, 16'hFFFF, 8'd1, 4'd0, 4'd0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        random_ticks(150);
        settle();

        // Random short setups; the last two run without idling
        for (int p = 0; p < 4; p++) begin
            if (p >= 2) idle_on = 1'b0;
            random_setup();
            random_ticks(80);
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && ticks_in_flight == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
